FILE: src/agcm_pkg.sv
`timescale 1ns / 1ps
package agcm_pkg;

  localparam int Rounds = 14;
  localparam int RkWords = 2 * (Rounds + 1);

  // input commands
  localparam logic [1:0] CMD_AAD    = 2'd0;
  localparam logic [1:0] CMD_CT     = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;   // dropped without effect

  // register indexes
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE_HI = 3'd4;
  localparam logic [2:0] REG_NONCE_LO = 3'd5;

  localparam logic [35:0] CountMax = 36'hF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  valid_bytes;
    logic        auth_ok;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KEYEXP, ST_ENC_H, ST_ENC_J0, ST_ENC_CTR, ST_ENC_RUN,
    ST_GHASH, ST_FINISH, ST_OUT
  } state_t;

  // control to the AES round unit
  typedef struct packed {
    logic         start;
    logic [127:0] block;
  } aes_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

FILE: src/agcm_aes_round.sv
`timescale 1ns / 1ps
// AES-256 encryption, one round per cycle over a shared round datapath.
// Round keys come from the caller, indexed by the round counter.
module agcm_aes_round (
  input  logic                   clk,
  input  logic                   rst_n,
  input  agcm_pkg::aes_ctl_t     ctl,
  output logic [3:0]             round,
  input  logic [127:0]           round_key,
  output logic                   done,
  output logic [127:0]           result
);
  import agcm_pkg::*;

  logic [127:0] st_r, st_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   mc [16];
  logic [127:0] ss, mx;

  assign round  = rnd_r;
  assign done   = done_r;
  assign result = st_r;

  // sub bytes, shift rows, mix columns; byte 0 is the msb
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4 * c] = sbox(st_r[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] h;
      h = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      mc[4*c]   = sb[4*c]   ^ h ^ xt(sb[4*c]   ^ sb[4*c+1]);
      mc[4*c+1] = sb[4*c+1] ^ h ^ xt(sb[4*c+1] ^ sb[4*c+2]);
      mc[4*c+2] = sb[4*c+2] ^ h ^ xt(sb[4*c+2] ^ sb[4*c+3]);
      mc[4*c+3] = sb[4*c+3] ^ h ^ xt(sb[4*c+3] ^ sb[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      ss[127 - 8 * i -: 8] = sb[i];
      mx[127 - 8 * i -: 8] = mc[i];
    end
  end

  // round sequencer
  always_comb begin
    st_nxt   = st_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      st_nxt   = ctl.block;
      rnd_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rnd_r == 4'd0) begin
        st_nxt = st_r ^ round_key;
      end else if (rnd_r == 4'(Rounds)) begin
        st_nxt = ss ^ round_key;
      end else begin
        st_nxt = mx ^ round_key;
      end
      if (rnd_r == 4'(Rounds)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rnd_nxt = rnd_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    rnd_r <= rnd_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

FILE: src/aes256_gcm_decrypt.sv
`timescale 1ns / 1ps
// AES-256-GCM decryption engine, one beat at a time. AAD (cmd 0) and
// ciphertext (cmd 1) beats are hashed, each ciphertext beat returns one
// plaintext beat; finish (cmd 2) returns the tag verdict; cmd 3 is dropped.
// The first beat of a message first expands the key (one schedule word a
// cycle) and derives H and E(K,J0) with two passes of the single round
// unit. After that an AAD or finish beat keeps the input stalled through
// the GHASH load, 8 steps of 16 bits and the post, and a ciphertext beat
// through a start state and an AES pass ahead of the same steps. in_stall
// is high while a beat is in work; a finished result waits in the output
// register, and a beat that completes behind it holds in its last cycle
// until that register frees.
module aes256_gcm_decrypt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  agcm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output agcm_pkg::out_beat_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [5:0]          cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready
);
  import agcm_pkg::*;

  // configuration registers
  logic [63:0] key_r [4];
  logic [63:0] nonce_hi_r;
  logic [31:0] nonce_lo_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      REG_KEY0:     cfg_prdata = key_r[0];
      REG_KEY1:     cfg_prdata = key_r[1];
      REG_KEY2:     cfg_prdata = key_r[2];
      REG_KEY3:     cfg_prdata = key_r[3];
      REG_NONCE_HI: cfg_prdata = nonce_hi_r;
      REG_NONCE_LO: cfg_prdata = {32'd0, nonce_lo_r};
      default:      cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= 64'd0;
      nonce_hi_r <= 64'd0;
      nonce_lo_r <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY0:     key_r[0] <= cfg_pwdata;
        REG_KEY1:     key_r[1] <= cfg_pwdata;
        REG_KEY2:     key_r[2] <= cfg_pwdata;
        REG_KEY3:     key_r[3] <= cfg_pwdata;
        REG_NONCE_HI: nonce_hi_r <= cfg_pwdata;
        REG_NONCE_LO: nonce_lo_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  // state
  state_t       state_r, state_nxt;
  logic [127:0] rk_mem [RkWords/2];
  logic [31:0]  sched_r [8];     // sliding key schedule window
  logic [5:0]   wi_r, wi_nxt;    // schedule word index
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] hkey_r, hkey_nxt;
  logic [127:0] tmask_r, tmask_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0]  ctr_r, ctr_nxt;
  logic [35:0]  aad_r, aad_nxt, ct_r, ct_nxt;
  logic         open_r, open_nxt;
  in_beat_t     beat_r, beat_nxt;
  logic [127:0] blk_r, blk_nxt;   // masked data block
  logic [127:0] mask_r, mask_nxt;
  logic [127:0] pt_r, pt_nxt;     // plaintext waiting to be posted
  logic [4:0]   n_r, n_nxt;
  // ghash: X in gx_r, V running, Z accum, 16 bits a step
  logic [127:0] gx_r, gx_nxt, gv_r, gv_nxt, gz_r, gz_nxt;
  logic [2:0]   gstep_r, gstep_nxt;
  out_beat_t    out_r, out_nxt;
  logic         ovalid_r, ovalid_nxt;

  aes_ctl_t     actl;
  logic [3:0]   around;
  logic [127:0] arkey;
  logic         adone;
  logic [127:0] ares;

  agcm_aes_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .round(around),
    .round_key(arkey), .done(adone), .result(ares)
  );

  assign arkey = rk_mem[around];

  // key schedule step: new word from window
  logic [31:0] kw_t, kw_new;
  logic        kw_we;
  always_comb begin
    kw_t = sched_r[7];
    if (wi_r[2:0] == 3'd0) begin
      kw_t = sub_word({kw_t[23:0], kw_t[31:24]}) ^ {rcon_r, 24'd0};
    end else if (wi_r[2:0] == 3'd4) begin
      kw_t = sub_word(kw_t);
    end
    kw_new = sched_r[0] ^ kw_t;
  end

  // round key memory, one 32-bit lane per write
  logic [31:0] kw_wdata;
  logic [5:0]  kw_waddr;
  always_ff @(posedge clk) begin
    if (kw_we) begin
      rk_mem[kw_waddr[5:2]][127 - 32 * kw_waddr[1:0] -: 32] <= kw_wdata;
    end
  end

  // ghash digit step
  logic [127:0] gz_s, gv_s;
  always_comb begin
    gz_s = gz_r;
    gv_s = gv_r;
    for (int i = 0; i < 16; i++) begin
      if (gx_r[127 - i]) gz_s = gz_s ^ gv_s;
      gv_s = {1'b0, gv_s[127:1]} ^ (gv_s[0] ? {8'he1, 120'd0} : 128'd0);
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  logic [4:0]   n_in;
  logic [127:0] m_in;
  logic [36:0]  sum_a, sum_c;
  always_comb begin
    n_in = (in_data.byte_count == 5'd0 || in_data.byte_count > 5'd16) ? 5'd16
                                                                       : in_data.byte_count;
    m_in = ~(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff >> {n_in, 3'd0});
    sum_a = {1'b0, aad_r} + 37'(n_r);
    sum_c = {1'b0, ct_r} + 37'(n_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    wi_nxt = wi_r; rcon_nxt = rcon_r;
    hkey_nxt = hkey_r; tmask_nxt = tmask_r; acc_nxt = acc_r;
    ctr_nxt = ctr_r; aad_nxt = aad_r; ct_nxt = ct_r; open_nxt = open_r;
    beat_nxt = beat_r; blk_nxt = blk_r; mask_nxt = mask_r; n_nxt = n_r;
    pt_nxt = pt_r;
    gx_nxt = gx_r; gv_nxt = gv_r; gz_nxt = gz_r; gstep_nxt = gstep_r;
    out_nxt = out_r; ovalid_nxt = ovalid_r;
    actl = '0;
    kw_we = 1'b0; kw_wdata = kw_new; kw_waddr = wi_r;
    if (out_acc) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.cmd != CMD_UNUSED) begin
          beat_nxt = in_data;
          n_nxt    = n_in;
          mask_nxt = m_in;
          blk_nxt  = {in_data.data_high, in_data.data_low} & m_in;
          if (!open_r) begin
            wi_nxt = 6'd0;
            rcon_nxt = 8'h01;
            state_nxt = ST_KEYEXP;
          end else if (in_data.cmd == CMD_CT) begin
            state_nxt = ST_ENC_CTR;
          end else begin
            state_nxt = ST_GHASH;
          end
        end
      end
      ST_KEYEXP: begin
        // words 0..7 are the key itself, then one derived word a cycle
        kw_we = 1'b1;
        if (wi_r < 6'd8) begin
          kw_wdata = key_r[wi_r[2:1]][(wi_r[0] ? 31 : 63) -: 32];
        end else if (wi_r[2:0] == 3'd0) begin
          rcon_nxt = xt(rcon_r);
        end
        wi_nxt = wi_r + 6'd1;
        if (wi_r == 6'(4 * (Rounds + 1) - 1)) begin
          actl.start = 1'b1;
          actl.block = 128'd0;
          state_nxt = ST_ENC_H;
        end
      end
      ST_ENC_H: begin
        if (adone) begin
          hkey_nxt = ares;
          actl.start = 1'b1;
          actl.block = {nonce_hi_r, nonce_lo_r, 32'd1};
          state_nxt = ST_ENC_J0;
        end
      end
      ST_ENC_J0: begin
        if (adone) begin
          tmask_nxt = ares;
          acc_nxt = 128'd0; ctr_nxt = 32'd2; aad_nxt = 36'd0; ct_nxt = 36'd0;
          open_nxt = 1'b1;
          state_nxt = (beat_r.cmd == CMD_CT) ? ST_ENC_CTR : ST_GHASH;
        end
      end
      ST_ENC_CTR: begin
        actl.start = 1'b1;
        actl.block = {nonce_hi_r, nonce_lo_r, ctr_r};
        state_nxt = ST_ENC_RUN;
      end
      ST_ENC_RUN: begin
        if (adone) begin
          pt_nxt = (blk_r ^ ares) & mask_r;
          ctr_nxt = ctr_r + 32'd1;
          state_nxt = ST_GHASH;
        end
      end
      default: ;
    endcase
    // ghash entry/steps (shared by data and length block)
    if (state_r == ST_GHASH || state_r == ST_FINISH) begin
      if (gstep_r == 3'd0 && gz_r == 128'd0 && gv_r == 128'd0 && gx_r == 128'd0) begin
        // load
        gx_nxt = acc_r ^ ((beat_r.cmd == CMD_FINISH) ? {25'd0, aad_r, 3'd0, 25'd0, ct_r, 3'd0}
                                                       : blk_r);
        gv_nxt = hkey_r;
        gz_nxt = 128'd0;
        gstep_nxt = 3'd0;
        if (state_r == ST_GHASH) state_nxt = ST_FINISH;
      end
    end
    if (state_r == ST_FINISH) begin
      gz_nxt = gz_s;
      gv_nxt = gv_s;
      gx_nxt = {gx_r[111:0], 16'd0};
      gstep_nxt = gstep_r + 3'd1;
      if (gstep_r == 3'd7) begin
        acc_nxt = gz_s;
        gx_nxt = 128'd0; gv_nxt = 128'd0; gz_nxt = 128'd0; gstep_nxt = 3'd0;
        state_nxt = ST_OUT;
      end
    end
    // post once the output register is free
    if (state_r == ST_OUT && (!ovalid_r || out_acc)) begin
      state_nxt = ST_IDLE;
      case (beat_r.cmd)
        CMD_AAD: aad_nxt = sum_a[36] || sum_a[35:0] > CountMax ? CountMax : sum_a[35:0];
        CMD_CT: begin
          ct_nxt = sum_c[36] ? CountMax : sum_c[35:0];
          out_nxt = '{kind: 1'b0, plain_high: pt_r[127:64], plain_low: pt_r[63:0],
                      valid_bytes: n_r, auth_ok: 1'b0};
          ovalid_nxt = 1'b1;
        end
        CMD_FINISH: begin
          out_nxt = '{kind: 1'b1, plain_high: 64'd0, plain_low: 64'd0, valid_bytes: 5'd0,
                      auth_ok: ((acc_r ^ tmask_r) ^ {beat_r.data_high, beat_r.data_low})
                               == 128'd0};
          open_nxt = 1'b0;
          ovalid_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // schedule window shift
  always_ff @(posedge clk) begin
    if (state_r == ST_KEYEXP) begin
      for (int i = 0; i < 7; i++) sched_r[i] <= sched_r[i + 1];
      sched_r[7] <= kw_wdata;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt; blk_r <= blk_nxt; mask_r <= mask_nxt; n_r <= n_nxt;
    pt_r <= pt_nxt;
    hkey_r <= hkey_nxt; tmask_r <= tmask_nxt; out_r <= out_nxt;
    wi_r <= wi_nxt; rcon_r <= rcon_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r <= 128'd0; ctr_r <= 32'd2; aad_r <= 36'd0; ct_r <= 36'd0;
      open_r <= 1'b0; ovalid_r <= 1'b0;
      gx_r <= 128'd0; gv_r <= 128'd0; gz_r <= 128'd0; gstep_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      acc_r <= acc_nxt; ctr_r <= ctr_nxt; aad_r <= aad_nxt; ct_r <= ct_nxt;
      open_r <= open_nxt; ovalid_r <= ovalid_nxt;
      gx_r <= gx_nxt; gv_r <= gv_nxt; gz_r <= gz_nxt; gstep_r <= gstep_nxt;
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_stall) |=> ovalid_r) else $error("result dropped");
  a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && state_nxt == ST_IDLE && beat_r.cmd == CMD_FINISH) |=> !open_r)
    else $error("open after finish");

endmodule
